@@ hw/rtl/msr_pkg.sv @@
// ----------------------------------------------------------------------------
// msr_pkg
// Shared widths, codes and types of the multi-channel servo ramp core.
// ----------------------------------------------------------------------------
package msr_pkg;

  // Field widths
  localparam int CH_W      = 5;
  localparam int VAL_W     = 16;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;

  // Stream packing: channel in the low bits, then the pulse value, zero pad
  localparam int TDATA_W = 24;
  localparam int TPAD_W  = TDATA_W - CH_W - VAL_W;

  // Request kinds carried on tuser
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_PRESET = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE = 1'd1;

  localparam logic [CFG_W-1:0] MIN_PULSE_RST = 12'h000;
  localparam logic [CFG_W-1:0] MAX_PULSE_RST = 12'hFFF;

  // Result queue
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = 2;
  localparam int OUTQ_CNT_W = 3;

  // Decoded request, held in the first pipeline stage
  typedef struct packed {
    logic                    opcode;
    logic [CH_W-1:0]         channel;
    logic                    in_range;
    logic                    snap;
    logic                    done;
    logic                    frame_end;
    logic signed [VAL_W-1:0] new_target;
  } item_t;

  // One channel's stored state
  typedef struct packed {
    logic signed [VAL_W-1:0] target;
    logic signed [VAL_W-1:0] present;
    logic signed [VAL_W-1:0] increment;
  } entry_t;

  // One result
  typedef struct packed {
    logic [CH_W-1:0]         channel;
    logic signed [VAL_W-1:0] pulse;
    logic                    done;
    logic                    frame_end;
  } result_t;

  // Pipeline occupancy, used for input credit
  typedef struct packed {
    logic s1_busy;
    logic s2_busy;
  } pipe_stat_t;

endpackage

@@ hw/rtl/msr_front.sv @@
// ----------------------------------------------------------------------------
// msr_front
// Configuration registers, refresh tick counter, target clamp and request
// decode into the first pipeline stage.
// ----------------------------------------------------------------------------
module msr_front #(
  parameter int CHANNELS = 32,
  parameter int STEPS    = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [msr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [msr_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             in_fire,
  input  logic                             in_opcode,
  input  logic [msr_pkg::CH_W-1:0]         in_channel,
  input  logic signed [msr_pkg::VAL_W-1:0] in_target,
  input  logic                             in_frame_end,
  output msr_pkg::item_t                   s1_o,
  output logic                             s1_valid_o
);
  import msr_pkg::*;

  localparam int CW = $clog2(STEPS);
  localparam logic [CW-1:0] STEPS_M1 = CW'(STEPS - 1);
  localparam logic [CH_W+1:0] CH_LIMIT = (CH_W + 2)'(CHANNELS);
  localparam int XW = VAL_W + 1 - CFG_W;

  logic [CFG_W-1:0]        min_pulse_r;
  logic [CFG_W-1:0]        max_pulse_r;
  logic [CW-1:0]           tick_count_r;
  logic [CW-1:0]           tick_count_nxt;
  logic [CW-1:0]           count_step;
  logic                    is_tick;
  logic                    at_last;
  logic signed [VAL_W:0]   tv_x;
  logic signed [VAL_W:0]   lo_x;
  logic signed [VAL_W:0]   hi_x;
  logic signed [VAL_W-1:0] clamped;
  item_t                   s1_r;
  item_t                   s1_nxt;
  logic                    s1_valid_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_pulse_r <= MIN_PULSE_RST;
      max_pulse_r <= MAX_PULSE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MIN_PULSE: min_pulse_r <= cfg_data;
        CFG_MAX_PULSE: max_pulse_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Count within the frame: every tick item sees the bumped count
  assign is_tick    = (in_opcode == OP_TICK);
  assign at_last    = (tick_count_r == STEPS_M1);
  assign count_step = at_last ? '0 : tick_count_r + CW'(1);

  // Commit the count on the last tick item of a frame
  assign tick_count_nxt = (in_fire && is_tick && in_frame_end) ? count_step : tick_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r <= '0;
    end else begin
      tick_count_r <= tick_count_nxt;
    end
  end

  // Clamp the requested target: low bound first
  always_comb begin
    tv_x = {in_target[VAL_W-1], in_target};
    lo_x = $signed({{XW{1'b0}}, min_pulse_r});
    hi_x = $signed({{XW{1'b0}}, max_pulse_r});
    if (tv_x < lo_x) begin
      clamped = lo_x[VAL_W-1:0];
    end else if (tv_x > hi_x) begin
      clamped = hi_x[VAL_W-1:0];
    end else begin
      clamped = in_target;
    end
  end

  // Decode the request
  always_comb begin
    s1_nxt.opcode     = in_opcode;
    s1_nxt.channel    = in_channel;
    s1_nxt.in_range   = ({2'b00, in_channel} < CH_LIMIT);
    s1_nxt.snap       = is_tick && at_last;
    s1_nxt.done       = is_tick ? (count_step == STEPS_M1) : at_last;
    s1_nxt.frame_end  = in_frame_end;
    s1_nxt.new_target = is_tick ? clamped : in_target;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1_o       = s1_r;
  assign s1_valid_o = s1_valid_r;

  // The count never leaves its range
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    tick_count_r <= STEPS_M1)
    else $error("tick count beyond last step");

  // A preset never moves the count
  a_preset_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_opcode == OP_PRESET) |=> $stable(tick_count_r))
    else $error("preset changed tick count");

endmodule

@@ hw/rtl/msr_pipe.sv @@
// ----------------------------------------------------------------------------
// msr_pipe
// Channel state memory and its read-modify-write pipeline: read on accept,
// update in stage 1 with forwarding, write back from stage 2.
// ----------------------------------------------------------------------------
module msr_pipe #(
  parameter int CHANNELS = 32,
  parameter int STEPS    = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_fire,
  input  logic [msr_pkg::CH_W-1:0] rd_channel,
  input  msr_pkg::item_t           s1_i,
  input  logic                     s1_valid_i,
  output logic                     push_o,
  output msr_pkg::result_t         res_o,
  output msr_pkg::pipe_stat_t      stat_o
);
  import msr_pkg::*;

  // Memory geometry: channel numbers above the field width never reach it
  localparam int AW = (CHANNELS >= 32) ? CH_W : ((CHANNELS < 2) ? 1 : $clog2(CHANNELS));
  localparam int MEM_DEPTH = 2 ** AW;

  // Truncating divide by STEPS as multiply by a rounded-up reciprocal
  localparam int MAG_W = VAL_W + 1;
  localparam int SH    = MAG_W + $clog2(STEPS);
  localparam int RW    = VAL_W + 3;
  localparam int PW    = SH + MAG_W;
  localparam logic [RW-1:0] RECIP = RW'(((2 ** SH) + STEPS - 1) / STEPS);

  entry_t                  mem_r [MEM_DEPTH];
  logic [MEM_DEPTH-1:0]    ent_ok_r;
  entry_t                  rd_r;
  logic                    rd_ok_r;
  logic [AW-1:0]           ra;
  logic [AW-1:0]           s1_addr;
  entry_t                  base;
  entry_t                  cur;
  logic signed [VAL_W-1:0] sum;
  logic signed [VAL_W:0]   d_pos;
  logic signed [VAL_W:0]   d_neg;
  logic [MAG_W-1:0]        mag;
  logic [PW-1:0]           prod;
  logic signed [VAL_W-1:0] s1_tgt;
  logic signed [VAL_W-1:0] s1_pres;

  logic                    s2_v_r;
  logic                    s2_we_r;
  logic [AW-1:0]           s2_addr_r;
  logic signed [VAL_W-1:0] s2_tgt_r;
  logic signed [VAL_W-1:0] s2_pres_r;
  logic signed [VAL_W-1:0] s2_keep_r;
  logic                    s2_snap_r;
  logic                    s2_neg_r;
  logic [VAL_W-1:0]        s2_quo_r;
  result_t                 s2_res_r;
  result_t                 s2_res_nxt;
  entry_t                  s2_wdata;
  logic [VAL_W-1:0]        s2_inc;

  logic                    w_we_r;
  logic [AW-1:0]           w_addr_r;
  entry_t                  w_data_r;

  assign ra      = rd_channel[AW-1:0];
  assign s1_addr = s1_i.channel[AW-1:0];

  // Read on accept, write back from stage 2 (read returns the old word)
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_r <= mem_r[ra];
    end
    if (s2_we_r) begin
      mem_r[s2_addr_r] <= s2_wdata;
    end
  end

  // Entry valid bits: an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_ok_r <= '0;
    end else if (s2_we_r) begin
      ent_ok_r[s2_addr_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_ok_r <= ent_ok_r[ra];
    end
  end

  // Forward the newest copy: stage 2 first, then the word written last cycle
  always_comb begin
    base = rd_ok_r ? rd_r : '0;
    if (s2_we_r && (s2_addr_r == s1_addr)) begin
      cur = s2_wdata;
    end else if (w_we_r && (w_addr_r == s1_addr)) begin
      cur = w_data_r;
    end else begin
      cur = base;
    end
  end

  // Stage 1: step, snap or preset
  assign sum   = cur.present + cur.increment;
  assign d_pos = {s1_i.new_target[VAL_W-1], s1_i.new_target} - {cur.target[VAL_W-1], cur.target};
  assign d_neg = {cur.target[VAL_W-1], cur.target} - {s1_i.new_target[VAL_W-1], s1_i.new_target};
  assign mag   = d_pos[VAL_W] ? $unsigned(d_neg) : $unsigned(d_pos);
  assign prod  = PW'(mag) * PW'(RECIP);

  always_comb begin
    if (s1_i.opcode == OP_PRESET) begin
      s1_tgt  = s1_i.new_target;
      s1_pres = s1_i.new_target;
    end else if (s1_i.snap) begin
      s1_tgt  = s1_i.new_target;
      s1_pres = cur.target;
    end else begin
      s1_tgt  = cur.target;
      s1_pres = sum;
    end
  end

  always_comb begin
    s2_res_nxt.channel   = s1_i.channel;
    s2_res_nxt.pulse     = s1_i.in_range ? s1_pres : '0;
    s2_res_nxt.done      = s1_i.done;
    s2_res_nxt.frame_end = s1_i.frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      s2_we_r <= 1'b0;
      w_we_r  <= 1'b0;
    end else begin
      s2_v_r  <= s1_valid_i;
      s2_we_r <= s1_valid_i && s1_i.in_range;
      w_we_r  <= s2_we_r;
    end
  end

  // Stage 2 payload
  always_ff @(posedge clk) begin
    s2_addr_r <= s1_addr;
    s2_tgt_r  <= s1_tgt;
    s2_pres_r <= s1_pres;
    s2_keep_r <= cur.increment;
    s2_snap_r <= (s1_i.opcode == OP_TICK) && s1_i.snap;
    s2_neg_r  <= d_pos[VAL_W];
    s2_quo_r  <= prod[SH +: VAL_W];
    s2_res_r  <= s2_res_nxt;
    w_addr_r  <= s2_addr_r;
    w_data_r  <= s2_wdata;
  end

  // Stage 2: restore the sign of the new increment
  assign s2_inc = s2_neg_r ? ((~s2_quo_r) + VAL_W'(1)) : s2_quo_r;

  always_comb begin
    s2_wdata.target    = s2_tgt_r;
    s2_wdata.present   = s2_pres_r;
    s2_wdata.increment = s2_snap_r ? $signed(s2_inc) : s2_keep_r;
  end

  assign push_o         = s2_v_r;
  assign res_o          = s2_res_r;
  assign stat_o.s1_busy = s1_valid_i;
  assign stat_o.s2_busy = s2_v_r;

endmodule

@@ hw/rtl/msr_outq.sv @@
// ----------------------------------------------------------------------------
// msr_outq
// Small result queue that decouples the pipeline from a stalling receiver.
// ----------------------------------------------------------------------------
module msr_outq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push_i,
  input  msr_pkg::result_t               data_i,
  input  logic                           pop_i,
  output logic                           valid_o,
  output msr_pkg::result_t               data_o,
  output logic [msr_pkg::OUTQ_CNT_W-1:0] count_o
);
  import msr_pkg::*;

  result_t               buf_r [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wp_r;
  logic [OUTQ_PTR_W-1:0] rp_r;
  logic [OUTQ_CNT_W-1:0] cnt_r;
  logic [OUTQ_CNT_W-1:0] cnt_nxt;
  logic                  pop;

  assign pop     = pop_i && (cnt_r != '0);
  assign cnt_nxt = cnt_r + OUTQ_CNT_W'(push_i) - OUTQ_CNT_W'(pop);

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_i) begin
        wp_r <= wp_r + OUTQ_PTR_W'(1);
      end
      if (pop) begin
        rp_r <= rp_r + OUTQ_PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Hold results
  always_ff @(posedge clk) begin
    if (push_i) begin
      buf_r[wp_r] <= data_i;
    end
  end

  assign valid_o = (cnt_r != '0);
  assign data_o  = buf_r[rp_r];
  assign count_o = cnt_r;

  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_i && !pop && (cnt_r == OUTQ_CNT_W'(OUTQ_DEPTH))))
    else $error("result queue overflow");

endmodule

@@ hw/rtl/multi_channel_servo_ramp_core.sv @@
// ----------------------------------------------------------------------------
// multi_channel_servo_ramp_core
// Ramps per-channel servo pulse widths toward clamped targets in STEPS ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one request per channel. tuser = 0 is a refresh tick,
//   tuser = 1 presets target and present width. tlast marks the last channel
//   of a refresh tick. tdata holds channel and requested width.
//   Output stream: one result per request, in order, with the channel, the
//   present width after the update, move done on tuser and tlast copied.
//   Config channel: write min_pulse (index 0) or max_pulse (index 1) while
//   the core is idle; it is always ready.
// Timing:
//   A request is accepted per cycle while tready is high. Its result passes
//   through the state read, update in stage 1, write back in stage 2, then
//   the result queue. Channel state sits in one memory, read at accept and
//   written back from stage 2; back-to-back requests on one channel are
//   forwarded, so the rate holds for any channel order.
// Reset and stall:
//   Reset clears the tick count, the config registers and every channel's
//   state at once. A stalled receiver fills a four-entry result queue; tready
//   drops once queued plus in-flight results reach four.
// ----------------------------------------------------------------------------
module multi_channel_servo_ramp_core #(
  parameter int CHANNELS = 32,
  parameter int STEPS    = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [msr_pkg::TDATA_W-1:0]       in_tdata,   // channel[4:0], target_value[20:5], pad
  input  logic                              in_tlast,   // frame_end
  input  logic                              in_tuser,   // opcode
  // Result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [msr_pkg::TDATA_W-1:0]       out_tdata,  // out_channel[4:0], pulse_value[20:5], pad
  output logic                              out_tlast,  // out_frame_end
  output logic                              out_tuser,  // move_done
  // Configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [msr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [msr_pkg::CFG_W-1:0]         cfg_data
);
  import msr_pkg::*;

  logic                    in_fire;
  logic [CH_W-1:0]         in_channel;
  logic signed [VAL_W-1:0] in_target;
  item_t                   s1;
  logic                    s1_valid;
  logic                    push;
  result_t                 res;
  pipe_stat_t              stat;
  result_t                 q_data;
  logic [OUTQ_CNT_W-1:0]   q_count;
  logic [OUTQ_CNT_W-1:0]   pending;

  // Unpack the request
  assign in_channel = in_tdata[CH_W-1:0];
  assign in_target  = $signed(in_tdata[CH_W +: VAL_W]);

  // Accept only when every in-flight result has a queue slot
  assign pending   = q_count + OUTQ_CNT_W'(stat.s1_busy) + OUTQ_CNT_W'(stat.s2_busy);
  assign in_tready = (pending < OUTQ_CNT_W'(OUTQ_DEPTH));
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  msr_front #(
    .CHANNELS (CHANNELS),
    .STEPS    (STEPS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_fire      (in_fire),
    .in_opcode    (in_tuser),
    .in_channel   (in_channel),
    .in_target    (in_target),
    .in_frame_end (in_tlast),
    .s1_o         (s1),
    .s1_valid_o   (s1_valid)
  );

  msr_pipe #(
    .CHANNELS (CHANNELS),
    .STEPS    (STEPS)
  ) u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .rd_channel (in_channel),
    .s1_i       (s1),
    .s1_valid_i (s1_valid),
    .push_o     (push),
    .res_o      (res),
    .stat_o     (stat)
  );

  msr_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .data_i  (res),
    .pop_i   (out_tready),
    .valid_o (out_tvalid),
    .data_o  (q_data),
    .count_o (q_count)
  );

  // Pack the result
  assign out_tdata = {{TPAD_W{1'b0}}, q_data.pulse, q_data.channel};
  assign out_tlast = q_data.frame_end;
  assign out_tuser = q_data.done;

  // Credit keeps queued plus in-flight results within the queue
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pending <= OUTQ_CNT_W'(OUTQ_DEPTH))
    else $error("in-flight results exceed queue space");

endmodule
